/* sv/ssa_pkg.sv */
// Shared types and constants for the slab slot allocator.
// No dependencies; every other file refers to it by scoped names.
package ssa_pkg;

    // Fixed field widths of the request and response beats
    localparam int unsigned KEY_W   = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned OCC_W   = 7;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_GET    = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // take the request beat and launch the slot read
        logic commit;   // update the store and load the response register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_busy; // response register holds a beat not yet taken
    } t_dp_stat;

endpackage

/* sv/ssa_if.sv */
// Request and response channel interfaces of the slab slot allocator.
// Depends on ssa_pkg for the field widths.
interface ssa_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic [ssa_pkg::KEY_W-1:0]    key;
    logic [ssa_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface ssa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ssa_pkg::STAT_W-1:0]   status;
    logic [ssa_pkg::KEY_W-1:0]    key_out;
    logic [ssa_pkg::VALUE_W-1:0]  value_out;
    logic [ssa_pkg::OCC_W-1:0]    occupied;

    modport source (output valid, output status, output key_out, output value_out,
                    output occupied, input ready);
    modport sink   (input valid, input status, input key_out, input value_out,
                    input occupied, output ready);
endinterface

/* sv/slab_slot_allocator_unit.sv */
// Slab slot allocator: a request beat is captured together with a registered read of
// its slot, then a read-modify-write commit updates the store and loads the response
// register; a pending response stalls commit, and no new request is taken until commit.
// Reset (synchronous, active low) empties the store: high-water mark, occupied
// count and free-list head go to zero; slot contents stay undefined until written.
module slab_slot_allocator_unit #(
    parameter int unsigned CAPACITY    = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssa_req_if.sink    i_req,
    ssa_rsp_if.source  o_rsp
);

    ssa_pkg::t_dp_cmd  cmd;
    ssa_pkg::t_dp_stat stat;

    // Sequencer
    ssa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath
    ssa_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (i_req.func),
        .i_key       (i_req.key),
        .i_value     (i_req.value),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_key_out   (o_rsp.key_out),
        .o_value_out (o_rsp.value_out),
        .o_occupied  (o_rsp.occupied)
    );

endmodule

/* sv/ssa_ctrl.sv */
// Operation sequencer of the slab slot allocator: accept, then commit.
// Depends on ssa_pkg for the state, command and status types.
module ssa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  ssa_pkg::t_dp_stat i_stat,
    output ssa_pkg::t_dp_cmd  o_cmd
);

    ssa_pkg::t_state r_state;
    ssa_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_req_ready   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            ssa_pkg::S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
                if (i_req_valid) begin
                    n_state = ssa_pkg::S_EXEC;
                end
            end
            ssa_pkg::S_EXEC: begin
                // wait here while the previous response is still pending
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ssa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssa_pkg::S_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ssa_pkg::S_EXEC))
        else $error("capture did not move the sequencer to execute");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_stat.out_busy)
        else $error("commit while the response register is occupied");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.commit))
        else $error("capture and commit in the same cycle");

endmodule

/* sv/ssa_dp.sv */
// Datapath of the slab slot allocator: slot memory, list registers, response register.
// Depends on ssa_pkg; driven by ssa_ctrl through t_dp_cmd.
module ssa_dp #(
    parameter int unsigned CAPACITY    = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssa_pkg::t_dp_cmd              i_cmd,
    output ssa_pkg::t_dp_stat             o_stat,
    input  logic [1:0]                    i_func,
    input  logic [ssa_pkg::KEY_W-1:0]     i_key,
    input  logic [ssa_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic [ssa_pkg::STAT_W-1:0]    o_status,
    output logic [ssa_pkg::KEY_W-1:0]     o_key_out,
    output logic [ssa_pkg::VALUE_W-1:0]   o_value_out,
    output logic [ssa_pkg::OCC_W-1:0]     o_occupied
);

    localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned SV_W   = (VALUE_WIDTH < ssa_pkg::VALUE_W) ?
                                     VALUE_WIDTH : ssa_pkg::VALUE_W;
    localparam int unsigned DATA_W = (SV_W > CNT_W) ? SV_W : CNT_W;
    localparam int unsigned CMP_W  = (CNT_W > ssa_pkg::KEY_W) ? CNT_W : ssa_pkg::KEY_W;
    localparam int unsigned VX_W   = (DATA_W > ssa_pkg::VALUE_W) ? DATA_W : ssa_pkg::VALUE_W;
    localparam int unsigned OX_W   = (CNT_W > ssa_pkg::OCC_W) ? CNT_W : ssa_pkg::OCC_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Slot memory: tag bit over payload or next-vacant index
    logic [DATA_W:0] r_slots [CAPACITY];

    ssa_pkg::t_func           r_func;
    logic [ssa_pkg::KEY_W-1:0] r_key;
    logic [SV_W-1:0]          r_value;
    logic [DATA_W:0]          r_rdata;
    logic [CNT_W-1:0]         r_high_water, n_high_water;
    logic [CNT_W-1:0]         r_occupied,   n_occupied;
    logic [CNT_W-1:0]         r_free_head,  n_free_head;

    logic                     r_rsp_valid;
    ssa_pkg::t_status         r_status,    n_status;
    logic [ssa_pkg::KEY_W-1:0] r_key_out,  n_key_out;
    logic [ssa_pkg::VALUE_W-1:0] r_value_out, n_value_out;
    logic [ssa_pkg::OCC_W-1:0] r_occ_out;

    logic [CMP_W-1:0]  in_key_wide;
    logic [IDX_W-1:0]  rd_addr;
    logic [CMP_W-1:0]  key_wide;
    logic [IDX_W-1:0]  key_idx;
    logic              key_oob;
    logic              rd_used;
    logic [DATA_W-1:0] rd_data;
    logic              list_empty;
    logic [CNT_W-1:0]  next_head;
    logic [IDX_W-1:0]  ins_idx;
    logic [CMP_W-1:0]  ins_wide;
    logic [VX_W-1:0]   rd_val_wide;
    logic [OX_W-1:0]   occ_wide;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W:0]   wr_data;

    assign o_stat.out_busy = r_rsp_valid && !i_rsp_ready;

    // Read address at capture: free-list head for insert, key otherwise
    assign in_key_wide = CMP_W'(i_key);
    assign rd_addr = (ssa_pkg::t_func'(i_func) == ssa_pkg::FN_INSERT) ?
                     r_free_head[IDX_W-1:0] : in_key_wide[IDX_W-1:0];

    // Capture the request and read its slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= ssa_pkg::t_func'(i_func);
            r_key   <= i_key;
            r_value <= i_value[SV_W-1:0];
            r_rdata <= r_slots[rd_addr];
        end
    end

    // Write the slot at commit
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slots[wr_addr] <= wr_data;
        end
    end

    // Decode the request against the list state
    assign key_wide    = CMP_W'(r_key);
    assign key_idx     = key_wide[IDX_W-1:0];
    assign key_oob     = (key_wide >= CMP_W'(r_high_water)) || (key_wide >= CMP_W'(CAPACITY));
    assign rd_used     = r_rdata[DATA_W];
    assign rd_data     = r_rdata[DATA_W-1:0];
    assign list_empty  = (r_free_head >= r_high_water);
    assign next_head   = (rd_data > DATA_W'(r_high_water)) ? r_high_water :
                         rd_data[CNT_W-1:0];
    assign ins_idx     = list_empty ? r_high_water[IDX_W-1:0] : r_free_head[IDX_W-1:0];
    assign ins_wide    = CMP_W'(ins_idx);
    assign rd_val_wide = VX_W'(rd_data);

    // Work out the operation's effect
    always_comb begin
        n_high_water = r_high_water;
        n_occupied   = r_occupied;
        n_free_head  = r_free_head;
        n_status     = ssa_pkg::ST_OK;
        n_key_out    = r_key;
        n_value_out  = '0;
        wr_en        = 1'b0;
        wr_addr      = ins_idx;
        wr_data      = {1'b1, DATA_W'(r_value)};
        case (r_func)
            ssa_pkg::FN_INSERT: begin
                if (list_empty && (r_high_water >= CAP_CNT)) begin
                    n_status  = ssa_pkg::ST_FULL;
                    n_key_out = '0;
                end else begin
                    wr_en      = i_cmd.commit;
                    n_occupied = r_occupied + CNT_W'(1);
                    n_key_out  = ins_wide[ssa_pkg::KEY_W-1:0];
                    if (list_empty) begin
                        n_high_water = r_high_water + CNT_W'(1);
                        n_free_head  = r_high_water + CNT_W'(1);
                    end else begin
                        n_free_head  = next_head;
                    end
                end
            end
            ssa_pkg::FN_REMOVE, ssa_pkg::FN_GET: begin
                if (key_oob || !rd_used) begin
                    n_status = ssa_pkg::ST_NOT_FOUND;
                end else begin
                    n_value_out = rd_val_wide[ssa_pkg::VALUE_W-1:0];
                    if (r_func == ssa_pkg::FN_REMOVE) begin
                        wr_en       = i_cmd.commit;
                        wr_addr     = key_idx;
                        wr_data     = {1'b0, DATA_W'(r_free_head)};
                        n_free_head = CNT_W'(key_idx);
                        if (r_occupied != '0) begin
                            n_occupied = r_occupied - CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_high_water = '0;
                n_occupied   = '0;
                n_free_head  = '0;
            end
        endcase
    end

    assign occ_wide = OX_W'(n_occupied);

    // Advance the list state at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_water <= '0;
            r_occupied   <= '0;
            r_free_head  <= '0;
        end else if (i_cmd.commit) begin
            r_high_water <= n_high_water;
            r_occupied   <= n_occupied;
            r_free_head  <= n_free_head;
        end
    end

    // Response register: load at commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status    <= n_status;
            r_key_out   <= n_key_out;
            r_value_out <= n_value_out;
            r_occ_out   <= occ_wide[ssa_pkg::OCC_W-1:0];
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_status    = r_status;
    assign o_key_out   = r_key_out;
    assign o_value_out = r_value_out;
    assign o_occupied  = r_occ_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occupied <= r_high_water) && (r_high_water <= CAP_CNT))
        else $error("occupied count or high-water mark out of bounds");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= r_high_water)
        else $error("free-list head beyond the high-water mark");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(i_cmd.commit))
        else $error("response appeared without a commit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> i_cmd.commit)
        else $error("slot written outside a commit");

endmodule

/* verif/slab_slot_allocator_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for slab_slot_allocator_unit: table-driven directed ops, then random
// fill/drain/mixed traffic checked beat by beat against a behavioral slab model.
// Depends on ssa_pkg, ssa_req_if / ssa_rsp_if and the allocator RTL.
module slab_slot_allocator_unit_tb;

    // Local names for the shared widths and codes
    localparam int unsigned KEY_W   = ssa_pkg::KEY_W;
    localparam int unsigned VALUE_W = ssa_pkg::VALUE_W;
    localparam int unsigned OCC_W   = ssa_pkg::OCC_W;

    typedef ssa_pkg::t_func   t_func;
    typedef ssa_pkg::t_status t_status;

    localparam t_func   FN_INSERT    = ssa_pkg::FN_INSERT;
    localparam t_func   FN_REMOVE    = ssa_pkg::FN_REMOVE;
    localparam t_func   FN_GET       = ssa_pkg::FN_GET;
    localparam t_func   FN_CLEAR     = ssa_pkg::FN_CLEAR;
    localparam t_status ST_OK        = ssa_pkg::ST_OK;
    localparam t_status ST_NOT_FOUND = ssa_pkg::ST_NOT_FOUND;
    localparam t_status ST_FULL      = ssa_pkg::ST_FULL;

    localparam int unsigned CAPACITY    = 64;
    localparam int unsigned IDLE_PCT    = 29;
    localparam int unsigned DIR_N       = 23;
    localparam int unsigned RAND_N      = 550;
    localparam int unsigned OP_TOTAL    = DIR_N + RAND_N;
    localparam int unsigned CALM_LO     = 300;
    localparam int unsigned CALM_HI     = 390;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        t_func                func;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
    } t_slab_op;

    typedef struct packed {
        t_status              status;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
        logic [OCC_W-1:0]     occ;
    } t_slab_reply;

    // Directed row: operation, then a typed reply where chk is set
    typedef struct {
        t_func                func;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
        bit                   chk;
        t_status              e_status;
        logic [KEY_W-1:0]     e_key;
        logic [VALUE_W-1:0]   e_value;
        logic [OCC_W-1:0]     e_occ;
    } t_op_row;

    t_op_row op_table [DIR_N] = '{
        '{FN_INSERT, 6'd0,  32'h0000_0000, 1'b1, ST_OK,        6'd0,  32'h0000_0000, 7'd1},
        '{FN_INSERT, 6'd9,  32'hFFFF_FFFF, 1'b1, ST_OK,        6'd1,  32'h0000_0000, 7'd2},
        '{FN_GET,    6'd0,  32'h0000_0000, 1'b1, ST_OK,        6'd0,  32'h0000_0000, 7'd2},
        '{FN_GET,    6'd1,  32'h1234_5678, 1'b1, ST_OK,        6'd1,  32'hFFFF_FFFF, 7'd2},
        '{FN_REMOVE, 6'd0,  32'h0000_0000, 1'b1, ST_OK,        6'd0,  32'h0000_0000, 7'd1},
        '{FN_GET,    6'd0,  32'h0000_0000, 1'b1, ST_NOT_FOUND, 6'd0,  32'h0000_0000, 7'd1},
        '{FN_REMOVE, 6'd0,  32'h0000_0000, 1'b1, ST_NOT_FOUND, 6'd0,  32'h0000_0000, 7'd1},
        '{FN_INSERT, 6'd0,  32'h1234_5678, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_INSERT, 6'd0,  32'h5A5A_5A5A, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_REMOVE, 6'd1,  32'h0000_0000, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_REMOVE, 6'd2,  32'h0000_0000, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_INSERT, 6'd0,  32'hA5A5_A5A5, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_INSERT, 6'd0,  32'h0000_0001, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_GET,    6'd2,  32'h0000_0000, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_INSERT, 6'd0,  32'h8000_0000, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_CLEAR,  6'd63, 32'hFFFF_FFFF, 1'b1, ST_OK,        6'd63, 32'h0000_0000, 7'd0},
        '{FN_GET,    6'd1,  32'h0000_0000, 1'b1, ST_NOT_FOUND, 6'd1,  32'h0000_0000, 7'd0},
        '{FN_REMOVE, 6'd3,  32'h0000_0000, 1'b1, ST_NOT_FOUND, 6'd3,  32'h0000_0000, 7'd0},
        '{FN_CLEAR,  6'd0,  32'h0000_0000, 1'b1, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_INSERT, 6'd42, 32'h7FFF_FFFF, 1'b1, ST_OK,        6'd0,  32'h0000_0000, 7'd1},
        '{FN_GET,    6'd0,  32'h0000_0000, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_REMOVE, 6'd0,  32'h0000_0000, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0},
        '{FN_INSERT, 6'd0,  32'hDEAD_BEEF, 1'b0, ST_OK,        6'd0,  32'h0000_0000, 7'd0}
    };

    logic clk;
    logic rst_n;

    ssa_req_if req_if();
    ssa_rsp_if rsp_if();

    slab_slot_allocator_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Slab model state
    logic               slot_used [CAPACITY];
    logic [VALUE_W-1:0] slot_data [CAPACITY];
    int unsigned        hw_mark;
    int unsigned        occ_cnt;
    int unsigned        free_ptr;
    int unsigned        hw_peak;    // highest mark since reset: keys below it were written

    t_slab_reply        due_replies [$];
    t_slab_op           cur_op;
    int unsigned        op_idx;
    int unsigned        reply_cnt;
    int unsigned        cycle_cnt;
    int unsigned        err_cnt;

    always #5 clk = ~clk;

    // Apply one operation to the slab model and return its reply
    function automatic t_slab_reply slab_apply(t_slab_op op);
        t_slab_reply rs;
        int unsigned k;
        rs.status = ST_OK;
        rs.key    = op.key;
        rs.value  = '0;
        case (op.func)
            FN_INSERT: begin
                if (free_ptr >= hw_mark) begin
                    if (hw_mark >= CAPACITY) begin
                        rs.status = ST_FULL;
                        rs.key    = '0;
                    end else begin
                        k            = hw_mark;
                        slot_used[k] = 1'b1;
                        slot_data[k] = op.value;
                        hw_mark      = k + 1;
                        free_ptr     = hw_mark;
                        occ_cnt++;
                        rs.key       = k[KEY_W-1:0];
                        if (hw_mark > hw_peak) hw_peak = hw_mark;
                    end
                end else begin
                    // pop the free-list head; its link sits in the slot itself
                    k            = free_ptr;
                    free_ptr     = (slot_data[k] > hw_mark) ? hw_mark : slot_data[k];
                    slot_used[k] = 1'b1;
                    slot_data[k] = op.value;
                    occ_cnt++;
                    rs.key       = k[KEY_W-1:0];
                end
            end
            FN_REMOVE, FN_GET: begin
                if (op.key >= hw_mark || !slot_used[op.key]) begin
                    rs.status = ST_NOT_FOUND;
                end else begin
                    rs.value = slot_data[op.key];
                    if (op.func == FN_REMOVE) begin
                        slot_used[op.key] = 1'b0;
                        slot_data[op.key] = free_ptr;
                        free_ptr          = 32'(op.key);
                        if (occ_cnt > 0) occ_cnt--;
                    end
                end
            end
            default: begin
                hw_mark  = 0;
                occ_cnt  = 0;
                free_ptr = 0;
            end
        endcase
        rs.occ = occ_cnt[OCC_W-1:0];
        return rs;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Request side: predict on each accepted beat, then present the next op
    always @(posedge clk) begin : drive_req
        t_slab_reply pred;
        t_func       f;
        int unsigned roll;
        int unsigned phase;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            op_idx    = 0;
            hw_mark   = 0;
            occ_cnt   = 0;
            free_ptr  = 0;
            hw_peak   = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                pred = slab_apply(cur_op);
                if (op_idx < DIR_N && op_table[op_idx].chk) begin
                    pred.status = op_table[op_idx].e_status;
                    pred.key    = op_table[op_idx].e_key;
                    pred.value  = op_table[op_idx].e_value;
                    pred.occ    = op_table[op_idx].e_occ;
                end
                due_replies = {due_replies, pred};
                op_idx++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (op_idx >= OP_TOTAL ||
                    (!(op_idx >= CALM_LO && op_idx < CALM_HI) &&
                     $urandom_range(0, 99) < IDLE_PCT)) begin
                    req_if.valid <= 1'b0;
                end else begin
                    if (op_idx < DIR_N) begin
                        f = op_table[op_idx].func;
                        k = op_table[op_idx].key;
                        v = op_table[op_idx].value;
                    end else begin
                        // cycle through fill, drain and mixed phases of 100 ops
                        phase = ((op_idx - DIR_N) / 100) % 3;
                        roll  = $urandom_range(0, 99);
                        case (phase)
                            0:       f = (roll < 80) ? FN_INSERT : (roll < 88) ? FN_REMOVE
                                                                               : FN_GET;
                            1:       f = (roll < 20) ? FN_INSERT : (roll < 75) ? FN_REMOVE
                                       : (roll < 98) ? FN_GET : FN_CLEAR;
                            default: f = (roll < 45) ? FN_INSERT : (roll < 70) ? FN_REMOVE
                                       : (roll < 98) ? FN_GET : FN_CLEAR;
                        endcase
                        // lookups only touch slots that were written at some point
                        if ((f == FN_REMOVE || f == FN_GET) && hw_peak == 0) f = FN_INSERT;
                        if (f == FN_REMOVE || f == FN_GET) begin
                            if ($urandom_range(0, 99) < 85 && hw_mark > 0)
                                k = KEY_W'($urandom_range(0, hw_mark - 1));
                            else
                                k = KEY_W'($urandom_range(0, hw_peak - 1));
                        end else begin
                            k = KEY_W'($urandom_range(0, CAPACITY - 1));
                        end
                        roll = $urandom_range(0, 99);
                        v = (roll < 10) ? '0 : (roll < 20) ? '1 : $urandom;
                    end
                    cur_op.func  = f;
                    cur_op.key   = k;
                    cur_op.value = v;
                    req_if.valid <= 1'b1;
                    req_if.func  <= f;
                    req_if.key   <= k;
                    req_if.value <= v;
                end
            end
        end
    end

    // Response side: random back-pressure with a calm stretch
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= (reply_cnt >= CALM_LO && reply_cnt < CALM_HI) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each reply beat with the oldest prediction
    always @(posedge clk) begin : check_rsp
        t_slab_reply want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            reply_cnt <= reply_cnt + 1;
            if (due_replies.size() == 0) begin
                $display("%0t ns: unexpected reply: expected none, got status %0h key %0h",
                         $time, rsp_if.status, rsp_if.key_out);
                err_cnt++;
            end else begin
                want = due_replies.pop_front();
                check_field("status",    VALUE_W'(want.status), VALUE_W'(rsp_if.status));
                check_field("key_out",   VALUE_W'(want.key),    VALUE_W'(rsp_if.key_out));
                check_field("value_out", want.value,            rsp_if.value_out);
                check_field("occupied",  VALUE_W'(want.occ),    VALUE_W'(rsp_if.occupied));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.func   = FN_INSERT;
        req_if.key    = '0;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;
        reply_cnt     = 0;
        cycle_cnt     = 0;
        err_cnt       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // hold until every op is accepted and every reply checked, then let it settle
        @(posedge clk);
        while (op_idx < OP_TOTAL || due_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
